// ===== sv/pma_pkg.sv =====
// ----------------------------------------------------------------------------
// pma_pkg - polygon moments accumulator package
// Field widths, derived arithmetic widths, queue sizing and the edge command
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package pma_pkg;

    // Input field width (fixed) and the number of bits of it that count.
    localparam int COORD_W      = 12;
    localparam int COORD_BITS   = 12;
    localparam int MAX_VERTICES = 1024;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Edge term widths.
    localparam int PROD_W  = 2 * COORD_W;          // coordinate product
    localparam int CROSS_W = 2 * COORD_W + 1;      // cross product c
    localparam int SUM_W   = COORD_W + 1;          // x1 + x2
    localparam int QSUM_W  = 2 * COORD_W + 1;      // x1^2 + x1*x2 + x2^2
    localparam int QXY_W   = 2 * COORD_W + 2;      // mixed quadratic
    localparam int FM_W    = SUM_W + CROSS_W;      // first moment term
    localparam int SM_W    = QSUM_W + CROSS_W;     // second moment term
    localparam int SMXY_W  = QXY_W + CROSS_W;      // mixed moment term

    // Accumulator widths.
    localparam int ACC_AREA_W = 35;
    localparam int ACC_M1_W   = 47;
    localparam int ACC_M2_W   = 59;
    localparam int ACC_MXY_W  = 60;

    // Result field widths.
    localparam int AREA_W = 34;
    localparam int M1_W   = 46;
    localparam int M2_W   = 58;
    localparam int MXY_W  = 59;

    typedef enum logic [1:0] {
        CMD_CLEAR,   // start of polygon: zero the accumulators
        CMD_EDGE,    // add one edge
        CMD_CLOSE    // add closing edge and emit the result
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                    op;
        logic                       overflow;
        logic signed [COORD_W-1:0]  x1;
        logic signed [COORD_W-1:0]  y1;
        logic signed [COORD_W-1:0]  x2;
        logic signed [COORD_W-1:0]  y2;
    } cmd_t;

    // Take the low COORD_BITS bits and sign-extend them to the field width.
    function automatic logic signed [COORD_W-1:0] coord_of(input logic [COORD_W-1:0] raw);
        logic [COORD_W-1:0] v;
        for (int i = 0; i < COORD_W; i++)
        begin
            v[i] = (i < COORD_BITS) ? raw[i] : raw[COORD_BITS-1];
        end
        return signed'(v);
    endfunction

endpackage

// ===== sv/pma_front.sv =====
// ----------------------------------------------------------------------------
// pma_front - vertex intake
// Tracks first and previous vertex, vertex count and overflow, and turns each
// request into queue commands: clear or edge (none if dropped), close if last.
// ----------------------------------------------------------------------------
module pma_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pma_pkg::COORD_W-1:0]   vertex_x,
    input  logic signed [pma_pkg::COORD_W-1:0]   vertex_y,
    input  logic                                 last_vertex,
    input  logic                                 q_full,
    output logic                                 push,
    output pma_pkg::cmd_t                        push_cmd
);

    logic signed [pma_pkg::COORD_W-1:0] first_x_reg, first_x_next;
    logic signed [pma_pkg::COORD_W-1:0] first_y_reg, first_y_next;
    logic signed [pma_pkg::COORD_W-1:0] prev_x_reg, prev_x_next;
    logic signed [pma_pkg::COORD_W-1:0] prev_y_reg, prev_y_next;
    logic                               in_poly_reg, in_poly_next;
    logic [pma_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                               ovf_reg, ovf_next;
    logic                               pend_reg, pend_next;
    pma_pkg::cmd_t                      pend_cmd_reg, pend_cmd_next;

    logic                               accept;
    logic signed [pma_pkg::COORD_W-1:0] x_c, y_c;
    pma_pkg::cmd_t                      cmd_a, cmd_b;
    logic                               a_valid, b_valid;

    assign x_c      = pma_pkg::coord_of(vertex_x);
    assign y_c      = pma_pkg::coord_of(vertex_y);
    assign in_stall = pend_reg | q_full;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        in_poly_next = in_poly_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        cmd_a        = '0;
        cmd_b        = '0;
        a_valid      = 1'b0;
        b_valid      = 1'b0;

        if (!in_poly_reg)
        begin
            first_x_next = x_c;
            first_y_next = y_c;
            prev_x_next  = x_c;
            prev_y_next  = y_c;
            cnt_next     = pma_pkg::CNT_W'(1);
            ovf_next     = 1'b0;
            in_poly_next = 1'b1;
            cmd_a.op     = pma_pkg::CMD_CLEAR;
            a_valid      = 1'b1;
        end
        else if (cnt_reg < pma_pkg::CNT_W'(pma_pkg::MAX_VERTICES))
        begin
            prev_x_next = x_c;
            prev_y_next = y_c;
            cnt_next    = cnt_reg + pma_pkg::CNT_W'(1);
            cmd_a.op    = pma_pkg::CMD_EDGE;
            cmd_a.x1    = prev_x_reg;
            cmd_a.y1    = prev_y_reg;
            cmd_a.x2    = x_c;
            cmd_a.y2    = y_c;
            a_valid     = 1'b1;
        end
        else
        begin
            // vertex dropped, only the flag remembers it
            ovf_next = 1'b1;
        end

        if (last_vertex)
        begin
            in_poly_next   = 1'b0;
            cmd_b.op       = pma_pkg::CMD_CLOSE;
            cmd_b.overflow = ovf_next;
            cmd_b.x1       = prev_x_next;
            cmd_b.y1       = prev_y_next;
            cmd_b.x2       = first_x_next;
            cmd_b.y2       = first_y_next;
            b_valid        = 1'b1;
        end
    end

    // Queue write: a held second command goes first, once there is room.
    always_comb
    begin
        if (pend_reg)
        begin
            push      = ~q_full;
            push_cmd  = pend_cmd_reg;
            pend_next = q_full;
        end
        else
        begin
            push      = accept & (a_valid | b_valid);
            push_cmd  = a_valid ? cmd_a : cmd_b;
            pend_next = accept & a_valid & b_valid;
        end
        pend_cmd_next = accept ? cmd_b : pend_cmd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_poly_reg <= 1'b0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (accept)
            begin
                in_poly_reg <= in_poly_next;
                cnt_reg     <= cnt_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_cmd_reg <= pend_cmd_next;
        if (accept)
        begin
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
        end
    end

    a_close_ends_polygon: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_vertex) |=> !in_poly_reg)
        else $error("polygon still open after final vertex");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pma_pkg::CNT_W'(pma_pkg::MAX_VERTICES))
        else $error("vertex count beyond limit");

endmodule

// ===== sv/pma_queue.sv =====
// ----------------------------------------------------------------------------
// pma_queue - edge command queue
// Small show-ahead FIFO that decouples the vertex intake from the arithmetic.
// ----------------------------------------------------------------------------
module pma_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pma_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output pma_pkg::cmd_t  head
);

    pma_pkg::cmd_t                mem [pma_pkg::QUEUE_DEPTH];
    logic [pma_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [pma_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == pma_pkg::QCNT_W'(pma_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + pma_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - pma_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + pma_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pma_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("write into full command queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("read from empty command queue");

endmodule

// ===== sv/pma_back.sv =====
// ----------------------------------------------------------------------------
// pma_back - edge arithmetic and accumulation
// Three register stages form the Green's theorem terms of one edge, a fourth
// adds them into six accumulators and loads the result register.
// ----------------------------------------------------------------------------
module pma_back
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    input  pma_pkg::cmd_t                          cmd,
    output logic                                   cmd_pop,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pma_pkg::AREA_W-1:0]      area_twice,
    output logic signed [pma_pkg::M1_W-1:0]        moment_x_six,
    output logic signed [pma_pkg::M1_W-1:0]        moment_y_six,
    output logic signed [pma_pkg::M2_W-1:0]        moment_xx_twelve,
    output logic signed [pma_pkg::MXY_W-1:0]       moment_xy_twentyfour,
    output logic signed [pma_pkg::M2_W-1:0]        moment_yy_twelve,
    output logic                                   vertex_overflow
);

    logic adv;

    // stage 1: coordinate products and sums
    logic                                s1_valid_reg;
    pma_pkg::cmd_op_t                    s1_op_reg;
    logic                                s1_ovf_reg;
    logic signed [pma_pkg::PROD_W-1:0]   p_x1y2_reg, p_x2y1_reg, p_x1y1_reg, p_x2y2_reg;
    logic signed [pma_pkg::PROD_W-1:0]   p_x1x1_reg, p_x1x2_reg, p_x2x2_reg;
    logic signed [pma_pkg::PROD_W-1:0]   p_y1y1_reg, p_y1y2_reg, p_y2y2_reg;
    logic signed [pma_pkg::SUM_W-1:0]    s1_sx_reg, s1_sy_reg;

    // stage 2: cross product and quadratic factors
    logic                                s2_valid_reg;
    pma_pkg::cmd_op_t                    s2_op_reg;
    logic                                s2_ovf_reg;
    logic signed [pma_pkg::CROSS_W-1:0]  c_reg;
    logic signed [pma_pkg::SUM_W-1:0]    s2_sx_reg, s2_sy_reg;
    logic signed [pma_pkg::QSUM_W-1:0]   qx_reg, qy_reg;
    logic signed [pma_pkg::QXY_W-1:0]    qxy_reg;

    // stage 3: edge terms
    logic                                s3_valid_reg;
    pma_pkg::cmd_op_t                    s3_op_reg;
    logic                                s3_ovf_reg;
    logic signed [pma_pkg::CROSS_W-1:0]  t_area_reg;
    logic signed [pma_pkg::FM_W-1:0]     t_mx_reg, t_my_reg;
    logic signed [pma_pkg::SM_W-1:0]     t_mxx_reg, t_myy_reg;
    logic signed [pma_pkg::SMXY_W-1:0]   t_mxy_reg;

    // accumulators
    logic signed [pma_pkg::ACC_AREA_W-1:0] acc_area_reg, acc_area_next;
    logic signed [pma_pkg::ACC_M1_W-1:0]   acc_mx_reg, acc_mx_next;
    logic signed [pma_pkg::ACC_M1_W-1:0]   acc_my_reg, acc_my_next;
    logic signed [pma_pkg::ACC_M2_W-1:0]   acc_mxx_reg, acc_mxx_next;
    logic signed [pma_pkg::ACC_M2_W-1:0]   acc_myy_reg, acc_myy_next;
    logic signed [pma_pkg::ACC_MXY_W-1:0]  acc_mxy_reg, acc_mxy_next;

    logic out_valid_reg;
    logic s3_emit;

    // whole pipeline holds while an untaken result sits in the output register
    assign adv     = ~out_valid_reg | ~out_stall;
    assign cmd_pop = adv & cmd_valid;
    assign s3_emit = s3_valid_reg & (s3_op_reg == pma_pkg::CMD_CLOSE);

    assign acc_area_next = acc_area_reg + pma_pkg::ACC_AREA_W'(t_area_reg);
    assign acc_mx_next   = acc_mx_reg + pma_pkg::ACC_M1_W'(t_mx_reg);
    assign acc_my_next   = acc_my_reg + pma_pkg::ACC_M1_W'(t_my_reg);
    assign acc_mxx_next  = acc_mxx_reg + pma_pkg::ACC_M2_W'(t_mxx_reg);
    assign acc_myy_next  = acc_myy_reg + pma_pkg::ACC_M2_W'(t_myy_reg);
    assign acc_mxy_next  = acc_mxy_reg + pma_pkg::ACC_MXY_W'(t_mxy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= cmd_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            s1_op_reg  <= cmd.op;
            s1_ovf_reg <= cmd.overflow;
            p_x1y2_reg <= cmd.x1 * cmd.y2;
            p_x2y1_reg <= cmd.x2 * cmd.y1;
            p_x1y1_reg <= cmd.x1 * cmd.y1;
            p_x2y2_reg <= cmd.x2 * cmd.y2;
            p_x1x1_reg <= cmd.x1 * cmd.x1;
            p_x1x2_reg <= cmd.x1 * cmd.x2;
            p_x2x2_reg <= cmd.x2 * cmd.x2;
            p_y1y1_reg <= cmd.y1 * cmd.y1;
            p_y1y2_reg <= cmd.y1 * cmd.y2;
            p_y2y2_reg <= cmd.y2 * cmd.y2;
            s1_sx_reg  <= pma_pkg::SUM_W'(cmd.x1) + pma_pkg::SUM_W'(cmd.x2);
            s1_sy_reg  <= pma_pkg::SUM_W'(cmd.y1) + pma_pkg::SUM_W'(cmd.y2);

            // stage 2
            s2_op_reg  <= s1_op_reg;
            s2_ovf_reg <= s1_ovf_reg;
            s2_sx_reg  <= s1_sx_reg;
            s2_sy_reg  <= s1_sy_reg;
            c_reg      <= pma_pkg::CROSS_W'(p_x1y2_reg) - pma_pkg::CROSS_W'(p_x2y1_reg);
            qx_reg     <= pma_pkg::QSUM_W'(p_x1x1_reg) + pma_pkg::QSUM_W'(p_x1x2_reg)
                        + pma_pkg::QSUM_W'(p_x2x2_reg);
            qy_reg     <= pma_pkg::QSUM_W'(p_y1y1_reg) + pma_pkg::QSUM_W'(p_y1y2_reg)
                        + pma_pkg::QSUM_W'(p_y2y2_reg);
            qxy_reg    <= (pma_pkg::QXY_W'(p_x1y1_reg) <<< 1) + pma_pkg::QXY_W'(p_x1y2_reg)
                        + pma_pkg::QXY_W'(p_x2y1_reg) + (pma_pkg::QXY_W'(p_x2y2_reg) <<< 1);

            // stage 3
            s3_op_reg  <= s2_op_reg;
            s3_ovf_reg <= s2_ovf_reg;
            t_area_reg <= c_reg;
            t_mx_reg   <= s2_sx_reg * c_reg;
            t_my_reg   <= s2_sy_reg * c_reg;
            t_mxx_reg  <= qx_reg * c_reg;
            t_myy_reg  <= qy_reg * c_reg;
            t_mxy_reg  <= qxy_reg * c_reg;

            // accumulate
            if (s3_valid_reg)
            begin
                if (s3_op_reg == pma_pkg::CMD_CLEAR)
                begin
                    acc_area_reg <= '0;
                    acc_mx_reg   <= '0;
                    acc_my_reg   <= '0;
                    acc_mxx_reg  <= '0;
                    acc_myy_reg  <= '0;
                    acc_mxy_reg  <= '0;
                end
                else
                begin
                    acc_area_reg <= acc_area_next;
                    acc_mx_reg   <= acc_mx_next;
                    acc_my_reg   <= acc_my_next;
                    acc_mxx_reg  <= acc_mxx_next;
                    acc_myy_reg  <= acc_myy_next;
                    acc_mxy_reg  <= acc_mxy_next;
                end
            end

            if (s3_emit)
            begin
                area_twice           <= acc_area_next[pma_pkg::AREA_W-1:0];
                moment_x_six         <= acc_mx_next[pma_pkg::M1_W-1:0];
                moment_y_six         <= acc_my_next[pma_pkg::M1_W-1:0];
                moment_xx_twelve     <= acc_mxx_next[pma_pkg::M2_W-1:0];
                moment_xy_twentyfour <= acc_mxy_next[pma_pkg::MXY_W-1:0];
                moment_yy_twelve     <= acc_myy_next[pma_pkg::M2_W-1:0];
                vertex_overflow      <= s3_ovf_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s3_emit) |=> out_valid_reg)
        else $error("closing edge did not produce a result");

endmodule

// ===== sv/polygon_moments_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// polygon_moments_accumulator_top - polygon moments accumulator
// Streams polygon vertices and returns the exact Green's theorem sums for
// twice the area, six times the first moments and the scaled second moments.
// ----------------------------------------------------------------------------
// Throughput: one vertex per cycle while the queue has room; a kept final or
//   lone vertex holds the intake while its closing edge enters the queue.
// Result: out_valid follows the closing command through its hold (unless the
//   final vertex is dropped), the queue, three arithmetic stages, accumulate.
// Reset: rst_n clears the polygon tracking, the command queue and all pipeline
//   valids; the block then awaits the first vertex of a new polygon.
// ----------------------------------------------------------------------------
module polygon_moments_accumulator_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    // vertex requests
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pma_pkg::COORD_W-1:0]     vertex_x,
    input  logic signed [pma_pkg::COORD_W-1:0]     vertex_y,
    input  logic                                   last_vertex,

    // result requests
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pma_pkg::AREA_W-1:0]      area_twice,
    output logic signed [pma_pkg::M1_W-1:0]        moment_x_six,
    output logic signed [pma_pkg::M1_W-1:0]        moment_y_six,
    output logic signed [pma_pkg::M2_W-1:0]        moment_xx_twelve,
    output logic signed [pma_pkg::MXY_W-1:0]       moment_xy_twentyfour,
    output logic signed [pma_pkg::M2_W-1:0]        moment_yy_twelve,
    output logic                                   vertex_overflow
);

    // Front to queue
    logic           q_push;
    pma_pkg::cmd_t  q_push_cmd;
    logic           q_full;

    // Queue to back
    logic           q_pop;
    logic           q_not_empty;
    pma_pkg::cmd_t  q_head;

    // Intake: first/previous vertex, count and overflow tracking. Each vertex
    // becomes a clear, an edge or nothing (if dropped), plus a closing edge on the final one.
    pma_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (last_vertex),
        .q_full      (q_full),
        .push        (q_push),
        .push_cmd    (q_push_cmd)
    );

    // Short command queue so that output back-pressure does not reach the
    // intake at once.
    pma_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Arithmetic pipeline, accumulators and result register.
    pma_back u_back
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd_valid            (q_not_empty),
        .cmd                  (q_head),
        .cmd_pop              (q_pop),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .area_twice           (area_twice),
        .moment_x_six         (moment_x_six),
        .moment_y_six         (moment_y_six),
        .moment_xx_twelve     (moment_xx_twelve),
        .moment_xy_twentyfour (moment_xy_twentyfour),
        .moment_yy_twelve     (moment_yy_twelve),
        .vertex_overflow      (vertex_overflow)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - polygon moments accumulator regression
// Streams closed polygons into the block as vertex requests and checks every
// result request against a local moments predictor or hand-worked sums. A short
// table covers degenerate polygons, tiny triangles of both windings and the
// coordinate corners. Random polygons follow, one of them long enough to overflow
// the vertex store. Both sides idle at random; the sink holds off once for long.
// ----------------------------------------------------------------------------
module tb;

    // Run shape
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 1426;   // about 1450 vertex requests in all
    localparam int LONG_AT       = 400;    // script position of the overflowing polygon
    localparam int HOLDOFF_AFTER = 100;    // vertices taken before the long hold-off
    localparam int HOLDOFF_LEN   = 400;    // cycles the sink refuses results
    localparam int DRAIN_CYCLES  = 20;     // drain margin after the last expected result
    localparam int CYCLE_LIMIT   = 200000;

    // Expected value of a directed row: worked out by hand, or by the predictor.
    typedef enum {WANT_MODEL, WANT_ZERO, WANT_ONES, WANT_MINUS_ONES} want_t;

    // How the random coordinates of one polygon are drawn.
    typedef enum {SPAN_FULL, SPAN_NEAR_ZERO, SPAN_CORNERS} coord_span_t;

    // Stall behaviour of the result sink for one stretch.
    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_HEAVY} sink_mode_t;

    typedef struct {
        logic signed [pma_pkg::AREA_W-1:0] area_twice;
        logic signed [pma_pkg::M1_W-1:0]   moment_x_six;
        logic signed [pma_pkg::M1_W-1:0]   moment_y_six;
        logic signed [pma_pkg::M2_W-1:0]   moment_xx_twelve;
        logic signed [pma_pkg::MXY_W-1:0]  moment_xy_twentyfour;
        logic signed [pma_pkg::M2_W-1:0]   moment_yy_twelve;
        logic                              vertex_overflow;
    } moments_t;

    typedef struct {
        logic [pma_pkg::COORD_W-1:0] x;
        logic [pma_pkg::COORD_W-1:0] y;
        logic                        last;
        want_t                       want;
    } vertex_req_t;

    typedef struct {
        int    x;
        int    y;
        bit    last;
        want_t want;
    } table_row_t;

    // ------------------------------------------------------------------------
    // Directed table. Degenerate polygons (one or two vertices, or collinear)
    // give all-zero sums; the unit triangle gives all ones counterclockwise
    // and all minus ones clockwise. The corner squares and the alternating-bit
    // triangle go through the predictor.
    // ------------------------------------------------------------------------
    table_row_t directed_table [DIRECTED_ROWS] = '{
        '{-2048,  2047, 1'b1, WANT_ZERO},        // lone vertex, corner
        '{ 2047, -2048, 1'b1, WANT_ZERO},        // lone vertex, opposite corner
        '{-2048, -2048, 1'b0, WANT_ZERO},        // two vertices: out and back
        '{ 2047,  2047, 1'b1, WANT_ZERO},
        '{    0,     0, 1'b0, WANT_ONES},        // unit triangle, counterclockwise
        '{    1,     0, 1'b0, WANT_ONES},
        '{    0,     1, 1'b1, WANT_ONES},
        '{    0,     0, 1'b0, WANT_MINUS_ONES},  // unit triangle, clockwise
        '{    0,     1, 1'b0, WANT_MINUS_ONES},
        '{    1,     0, 1'b1, WANT_MINUS_ONES},
        '{-2048, -2048, 1'b0, WANT_MODEL},       // full-range square, counterclockwise
        '{ 2047, -2048, 1'b0, WANT_MODEL},
        '{ 2047,  2047, 1'b0, WANT_MODEL},
        '{-2048,  2047, 1'b1, WANT_MODEL},
        '{-2048,  2047, 1'b0, WANT_MODEL},       // same square, clockwise
        '{ 2047,  2047, 1'b0, WANT_MODEL},
        '{ 2047, -2048, 1'b0, WANT_MODEL},
        '{-2048, -2048, 1'b1, WANT_MODEL},
        '{   -1,    -1, 1'b0, WANT_MODEL},       // alternating bit patterns
        '{ 1365, -1366, 1'b0, WANT_MODEL},
        '{-1366,  1365, 1'b1, WANT_MODEL},
        '{    0,     0, 1'b0, WANT_ZERO},        // collinear: every cross product zero
        '{    5,     5, 1'b0, WANT_ZERO},
        '{   10,    10, 1'b1, WANT_ZERO}
    };

    // DUT connections; every input known from time zero
    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic in_valid    = 1'b0;
    logic in_stall;
    logic signed [pma_pkg::COORD_W-1:0] vertex_x = '0;
    logic signed [pma_pkg::COORD_W-1:0] vertex_y = '0;
    logic last_vertex = 1'b0;
    logic out_valid;
    logic out_stall   = 1'b0;
    logic signed [pma_pkg::AREA_W-1:0] area_twice;
    logic signed [pma_pkg::M1_W-1:0]   moment_x_six;
    logic signed [pma_pkg::M1_W-1:0]   moment_y_six;
    logic signed [pma_pkg::M2_W-1:0]   moment_xx_twelve;
    logic signed [pma_pkg::MXY_W-1:0]  moment_xy_twentyfour;
    logic signed [pma_pkg::M2_W-1:0]   moment_yy_twelve;
    logic vertex_overflow;

    // Predictor state, at its reset value
    bit     poly_open     = 1'b0;
    int     kept_vertices = 0;
    bit     poly_overflow = 1'b0;
    longint anchor_x = 0, anchor_y = 0;
    longint trail_x  = 0, trail_y  = 0;
    longint sum_area = 0, sum_mx = 0, sum_my = 0;
    longint sum_mxx  = 0, sum_myy = 0, sum_mxy = 0;

    // Scoreboard and run bookkeeping
    vertex_req_t vertex_script [$];
    moments_t    moments_due [$];
    int  mismatches       = 0;
    int  results_seen     = 0;
    int  overflow_results = 0;
    int  vertices_taken   = 0;
    int  burst_left       = 0;
    int  cycle_count      = 0;
    bit  holdoff_armed    = 1'b0;

    polygon_moments_accumulator_top dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .vertex_x             (vertex_x),
        .vertex_y             (vertex_y),
        .last_vertex          (last_vertex),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .area_twice           (area_twice),
        .moment_x_six         (moment_x_six),
        .moment_y_six         (moment_y_six),
        .moment_xx_twelve     (moment_xx_twelve),
        .moment_xy_twentyfour (moment_xy_twentyfour),
        .moment_yy_twelve     (moment_yy_twelve),
        .vertex_overflow      (vertex_overflow)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Moments predictor
    // ------------------------------------------------------------------------

    // Low COORD_BITS of the field, sign-extended.
    function automatic longint coord_value(input logic [pma_pkg::COORD_W-1:0] raw);
        longint v;
        v = longint'(raw) & ((longint'(1) << pma_pkg::COORD_BITS) - 1);
        if (raw[pma_pkg::COORD_BITS-1])
        begin
            v = v - (longint'(1) << pma_pkg::COORD_BITS);
        end
        return v;
    endfunction

    // Green's theorem terms of one side p1 -> p2.
    task automatic add_side(input longint x1, input longint y1,
                            input longint x2, input longint y2);
        longint c;
        c = x1 * y2 - x2 * y1;
        sum_area += c;
        sum_mx   += (x1 + x2) * c;
        sum_my   += (y1 + y2) * c;
        sum_mxx  += (x1 * x1 + x1 * x2 + x2 * x2) * c;
        sum_myy  += (y1 * y1 + y1 * y2 + y2 * y2) * c;
        sum_mxy  += (2 * x1 * y1 + x1 * y2 + x2 * y1 + 2 * x2 * y2) * c;
    endtask

    // Takes one vertex; on the final one closes the polygon and hands back its sums.
    task automatic accumulate_vertex(input vertex_req_t v, output bit closed,
                                     output moments_t m);
        longint x;
        longint y;
        x = coord_value(v.x);
        y = coord_value(v.y);
        closed = 1'b0;
        m = '{default: 0};
        if (!poly_open)
        begin
            // first vertex: fresh polygon
            anchor_x = x;
            anchor_y = y;
            trail_x = x;
            trail_y = y;
            kept_vertices = 1;
            poly_overflow = 1'b0;
            sum_area = 0;
            sum_mx = 0;
            sum_my = 0;
            sum_mxx = 0;
            sum_myy = 0;
            sum_mxy = 0;
            poly_open = 1'b1;
        end
        else if (kept_vertices < pma_pkg::MAX_VERTICES)
        begin
            add_side(trail_x, trail_y, x, y);
            trail_x = x;
            trail_y = y;
            kept_vertices++;
        end
        else
        begin
            // store full: vertex dropped, trailing vertex kept
            poly_overflow = 1'b1;
        end
        if (v.last)
        begin
            add_side(trail_x, trail_y, anchor_x, anchor_y);
            m.area_twice           = sum_area[pma_pkg::AREA_W-1:0];
            m.moment_x_six         = sum_mx[pma_pkg::M1_W-1:0];
            m.moment_y_six         = sum_my[pma_pkg::M1_W-1:0];
            m.moment_xx_twelve     = sum_mxx[pma_pkg::M2_W-1:0];
            m.moment_xy_twentyfour = sum_mxy[pma_pkg::MXY_W-1:0];
            m.moment_yy_twelve     = sum_myy[pma_pkg::M2_W-1:0];
            m.vertex_overflow      = poly_overflow;
            poly_open = 1'b0;
            closed = 1'b1;
        end
    endtask

    // All six sums equal to k, no overflow.
    function automatic moments_t uniform_moments(input longint k);
        moments_t m;
        m.area_twice           = k[pma_pkg::AREA_W-1:0];
        m.moment_x_six         = k[pma_pkg::M1_W-1:0];
        m.moment_y_six         = k[pma_pkg::M1_W-1:0];
        m.moment_xx_twelve     = k[pma_pkg::M2_W-1:0];
        m.moment_xy_twentyfour = k[pma_pkg::MXY_W-1:0];
        m.moment_yy_twelve     = k[pma_pkg::M2_W-1:0];
        m.vertex_overflow      = 1'b0;
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus script
    // ------------------------------------------------------------------------

    function automatic void queue_vertex(input int x, input int y, input bit last,
                                         input want_t want);
        vertex_req_t v;
        v.x    = x[pma_pkg::COORD_W-1:0];
        v.y    = y[pma_pkg::COORD_W-1:0];
        v.last = last;
        v.want = want;
        vertex_script.insert(vertex_script.size(), v);
    endfunction

    function automatic int random_coord(input coord_span_t span);
        int pick;
        pick = $urandom_range(0, 4);
        case (span)
            SPAN_NEAR_ZERO: return $urandom_range(0, 16) - 8;
            SPAN_CORNERS:   return (pick == 0) ? -2048 : (pick == 1) ? 2047 :
                                   (pick == 2) ? 0 : (pick == 3) ? -1 : 1;
            default:        return $urandom_range(0, 4095) - 2048;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Vertex sender: bursts of random length with random gaps. Entered just
    // after a falling edge and leaves just after one, so each input gets at
    // most one update per time step. The predictor runs on acceptance.
    // ------------------------------------------------------------------------
    task automatic offer_vertex(input vertex_req_t v);
        int       gap;
        bit       closed;
        moments_t got;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 48);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        in_valid    <= 1'b1;
        vertex_x    <= v.x;
        vertex_y    <= v.y;
        last_vertex <= v.last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        accumulate_vertex(v, closed, got);
        if (closed)
        begin
            case (v.want)
                WANT_ZERO:       got = uniform_moments(0);
                WANT_ONES:       got = uniform_moments(1);
                WANT_MINUS_ONES: got = uniform_moments(-1);
                default:         ;
            endcase
            moments_due.insert(moments_due.size(), got);
        end
        vertices_taken++;
        if (vertices_taken == HOLDOFF_AFTER)
        begin
            holdoff_armed = 1'b1;
        end
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: stretches of differing stall behaviour, plus one long
    // hold-off once the sender is well under way so that the block backs up
    // and stalls its vertex input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        sink_mode_t mode;
        int         span;
        int         pick;
        bit         holdoff_done;
        holdoff_done = 1'b0;
        wait (rst_n);
        forever
        begin
            if (holdoff_armed && !holdoff_done)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLDOFF_LEN - 1) @(negedge clk);
                holdoff_done = 1'b1;
            end
            pick = $urandom_range(0, 3);
            mode = (pick == 0) ? SINK_OPEN : (pick == 1) ? SINK_RANDOM :
                   (pick == 2) ? SINK_PERIODIC : SINK_HEAVY;
            span = $urandom_range(8, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    SINK_OPEN:     out_stall <= 1'b0;
                    SINK_RANDOM:   out_stall <= ($urandom_range(0, 99) < 35);
                    SINK_PERIODIC: out_stall <= (cycle_count % 3 == 0);
                    default:       out_stall <= ($urandom_range(0, 99) < 80);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result request against the oldest
    // expectation, field by field. First ten mismatches are printed.
    // ------------------------------------------------------------------------
    task automatic compare_field(input string fname, input longint want,
                                 input longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result %0d: %s expected %0d got %0d",
                         results_seen, fname, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        moments_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (vertex_overflow)
            begin
                overflow_results++;
            end
            if (moments_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d: unexpected, area_twice %0d",
                             results_seen, area_twice);
                end
            end
            else
            begin
                want = moments_due.pop_front();
                compare_field("area_twice", want.area_twice, area_twice);
                compare_field("moment_x_six", want.moment_x_six, moment_x_six);
                compare_field("moment_y_six", want.moment_y_six, moment_y_six);
                compare_field("moment_xx_twelve", want.moment_xx_twelve,
                              moment_xx_twelve);
                compare_field("moment_xy_twentyfour", want.moment_xy_twentyfour,
                              moment_xy_twentyfour);
                compare_field("moment_yy_twelve", want.moment_yy_twelve,
                              moment_yy_twelve);
                compare_field("vertex_overflow", want.vertex_overflow,
                              vertex_overflow);
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, moments_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the script, reset, stream it, drain, report.
    // ------------------------------------------------------------------------
    initial
    begin : main_flow
        int          n;
        int          pick;
        coord_span_t span;
        bit          long_done;
        long_done = 1'b0;

        foreach (directed_table[i])
        begin
            queue_vertex(directed_table[i].x, directed_table[i].y,
                         directed_table[i].last, directed_table[i].want);
        end

        // Random polygons: mostly well-formed with 3..12 vertices, some
        // degenerate, and one that runs two vertices past the store so that
        // both a dropped ordinary vertex and a dropped final vertex occur.
        while (vertex_script.size() < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (!long_done && vertex_script.size() > LONG_AT)
            begin
                n = pma_pkg::MAX_VERTICES + 2;
                span = SPAN_FULL;
                long_done = 1'b1;
            end
            else
            begin
                n = (pick < 8) ? $urandom_range(1, 2) : $urandom_range(3, 12);
                span = (pick < 55) ? SPAN_FULL : (pick < 80) ? SPAN_NEAR_ZERO
                                                             : SPAN_CORNERS;
            end
            for (int k = 0; k < n; k++)
            begin
                queue_vertex(random_coord(span), random_coord(span), k == n - 1,
                             WANT_MODEL);
            end
        end

        // reset held from time zero, released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (vertex_script[i])
        begin
            offer_vertex(vertex_script[i]);
        end
        in_valid <= 1'b0;

        while (moments_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d vertex requests in %0d cycles; checked %0d results",
                 vertices_taken, cycle_count, results_seen);
        $display("including %0d with vertex overflow, with a %0d cycle sink hold-off",
                 overflow_results, HOLDOFF_LEN);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
